// ===== rtl/core/id_allocator_lifo_recycle_assert.svh =====
// Assertion macros shared by the identifier allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ID_ALLOCATOR_LIFO_RECYCLE_ASSERT_SVH
`define ID_ALLOCATOR_LIFO_RECYCLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IDAL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idal assertion failed");

// Next-cycle implication, checked out of reset.
`define IDAL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idal assertion failed");

`endif

// ===== rtl/core/idal_pkg.sv =====
// Types and constants of the identifier allocator.
// No dependencies; used by the interfaces, the storage module and the top level.
package idal_pkg;

    localparam int ID_W  = 8;
    localparam int CMP_W = 9;
    localparam int STS_W = 2;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_BAD_FREE  = 2'd1;
    localparam logic [STS_W-1:0] ST_EXHAUSTED = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic            rd_en;
        logic [ID_W-1:0] stack_raddr;
        logic [ID_W-1:0] flag_raddr;
        logic            stack_we;
        logic [ID_W-1:0] stack_waddr;
        logic [ID_W-1:0] stack_wdata;
        logic            flag_we;
        logic [ID_W-1:0] flag_waddr;
        logic            flag_wdata;
    } mem_req_t;

    typedef struct packed {
        logic            busy;
        logic [ID_W-1:0] stack_rdata;
        logic            flag_rdata;
    } mem_rsp_t;

endpackage

// ===== rtl/core/idal_req_if.sv =====
// Request channel of the identifier allocator: valid, ready, mode and identifier.
// Depends on idal_pkg.
interface idal_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [idal_pkg::ID_W-1:0] id_in;

    modport source (output valid, output mode, output id_in, input ready);
    modport sink (input valid, input mode, input id_in, output ready);
endinterface

// ===== rtl/core/idal_rsp_if.sv =====
// Result channel of the identifier allocator: valid, ready, identifier and status.
// Depends on idal_pkg.
interface idal_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [idal_pkg::ID_W-1:0]  id_out;
    logic [idal_pkg::STS_W-1:0] status;

    modport source (output valid, output id_out, output status, input ready);
    modport sink (input valid, input id_out, input status, output ready);
endinterface

// ===== rtl/core/idal_store.sv =====
// Recycle stack memory and recycled flag memory, both with registered reads.
// Depends on idal_pkg; the flag memory is swept to zero after reset.
module idal_store #(
    parameter int DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  idal_pkg::mem_req_t mreq,
    output idal_pkg::mem_rsp_t mrsp
);
    localparam int IDX_W = $clog2(DEPTH);

    logic [idal_pkg::ID_W-1:0] stack_mem [DEPTH];
    logic                      flag_mem [DEPTH];

    logic [IDX_W-1:0]          clr_cnt_reg;
    logic                      busy_reg;
    logic [idal_pkg::ID_W-1:0] stack_rdata_reg;
    logic                      flag_rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if (clr_cnt_reg == IDX_W'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.stack_we)
        begin
            stack_mem[mreq.stack_waddr[IDX_W-1:0]] <= mreq.stack_wdata;
        end
        if (mreq.rd_en)
        begin
            stack_rdata_reg <= stack_mem[mreq.stack_raddr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            flag_mem[clr_cnt_reg] <= 1'b0;
        end
        else if (mreq.flag_we)
        begin
            flag_mem[mreq.flag_waddr[IDX_W-1:0]] <= mreq.flag_wdata;
        end
        if (mreq.rd_en)
        begin
            flag_rdata_reg <= flag_mem[mreq.flag_raddr[IDX_W-1:0]];
        end
    end

    assign mrsp.busy        = busy_reg;
    assign mrsp.stack_rdata = stack_rdata_reg;
    assign mrsp.flag_rdata  = flag_rdata_reg;
endmodule

// ===== rtl/core/id_allocator_lifo_recycle.sv =====
// Top level of the LIFO identifier allocator: control, counters and result register.
// Depends on idal_pkg, idal_req_if, idal_rsp_if, idal_store and the assertion header.
//
// Channel | Direction | Payload
// req     | in        | mode (alloc / free), id_in
// rsp     | out       | id_out, status
//
// Each request is handled in order: the stack and flag memories are read when it is
// accepted, then the decision state writes back and loads the result register.
// After reset the flag memory is cleared over all min(MAX_IDS, 256) entries; req.ready stays low meanwhile.
// A waiting result in the output register does not block acceptance of the next request;
// the decision cycle holds only while the output register is full and not taken.
`include "id_allocator_lifo_recycle_assert.svh"

module id_allocator_lifo_recycle #(
    parameter int MAX_IDS = 256
) (
    input logic        clk,
    input logic        rst_n,
    idal_req_if.sink   req,
    idal_rsp_if.source rsp
);
    localparam int ID_SPACE = (MAX_IDS < 256) ? MAX_IDS : 256;
    localparam int CNT_W    = $clog2(ID_SPACE + 1);
    localparam int CW       = idal_pkg::CMP_W;
    localparam int IW       = idal_pkg::ID_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                      state_reg;
    logic                        mode_reg;
    logic [IW-1:0]               id_reg;
    logic [CNT_W-1:0]            stack_count_reg;
    logic [CNT_W-1:0]            fresh_next_reg;
    logic                        rsp_valid_reg;
    logic [IW-1:0]               rsp_id_reg;
    logic [idal_pkg::STS_W-1:0]  rsp_status_reg;

    idal_pkg::mem_req_t          mreq;
    idal_pkg::mem_rsp_t          mrsp;

    logic                        accept;
    logic                        out_free;
    logic                        exec_fire;
    logic [CNT_W-1:0]            count_dec;
    logic                        do_pop;
    logic                        do_fresh;
    logic                        do_push;
    logic                        bad_free;
    logic [IW-1:0]               id_next;
    logic [idal_pkg::STS_W-1:0]  status_next;

    idal_store #(
        .DEPTH (ID_SPACE)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mreq),
        .mrsp  (mrsp)
    );

    assign req.ready = (state_reg == S_IDLE) && !mrsp.busy;
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign count_dec = stack_count_reg - CNT_W'(1);

    always_comb
    begin
        bad_free = (id_reg == '0)
                || (CW'(id_reg) >= CW'(fresh_next_reg))
                || (CW'(id_reg) >= CW'(ID_SPACE))
                || mrsp.flag_rdata
                || (stack_count_reg >= CNT_W'(ID_SPACE));
        do_pop      = 1'b0;
        do_fresh    = 1'b0;
        do_push     = 1'b0;
        id_next     = '0;
        status_next = idal_pkg::ST_OK;
        if (mode_reg == idal_pkg::MODE_ALLOC)
        begin
            if (stack_count_reg != '0)
            begin
                do_pop  = 1'b1;
                id_next = mrsp.stack_rdata;
            end
            else if (fresh_next_reg < CNT_W'(ID_SPACE))
            begin
                do_fresh = 1'b1;
                id_next  = IW'(CW'(fresh_next_reg));
            end
            else
            begin
                status_next = idal_pkg::ST_EXHAUSTED;
            end
        end
        else
        begin
            if (bad_free)
            begin
                status_next = idal_pkg::ST_BAD_FREE;
            end
            else
            begin
                do_push = 1'b1;
            end
        end
    end

    always_comb
    begin
        mreq.rd_en       = accept;
        mreq.stack_raddr = IW'(CW'(count_dec));
        mreq.flag_raddr  = req.id_in;
        mreq.stack_we    = exec_fire && do_push;
        mreq.stack_waddr = IW'(CW'(stack_count_reg));
        mreq.stack_wdata = id_reg;
        mreq.flag_we     = exec_fire && (do_push || do_pop);
        mreq.flag_waddr  = do_push ? id_reg : mrsp.stack_rdata;
        mreq.flag_wdata  = do_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stack_count_reg <= '0;
            fresh_next_reg  <= CNT_W'(1);
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (exec_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (do_pop)
                        begin
                            stack_count_reg <= count_dec;
                        end
                        if (do_push)
                        begin
                            stack_count_reg <= stack_count_reg + CNT_W'(1);
                        end
                        if (do_fresh)
                        begin
                            fresh_next_reg <= fresh_next_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            id_reg   <= req.id_in;
        end
        if (exec_fire)
        begin
            rsp_id_reg     <= id_next;
            rsp_status_reg <= status_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.id_out = rsp_id_reg;
    assign rsp.status = rsp_status_reg;

    // The stack count stays below the fresh counter: every stacked identifier is distinct and below it.
    `IDAL_ASSERT_IMP(a_count_below_fresh, 1'b1, stack_count_reg < fresh_next_reg)
    `IDAL_ASSERT_IMP(a_fresh_in_range, 1'b1,
        (fresh_next_reg != '0) && (fresh_next_reg <= CNT_W'(ID_SPACE)))
    `IDAL_ASSERT_IMP(a_no_accept_in_clear, mrsp.busy, !req.ready)
    `IDAL_ASSERT_NXT(a_pop_decrements, exec_fire && do_pop,
        stack_count_reg == $past(stack_count_reg) - CNT_W'(1))
    `IDAL_ASSERT_IMP(a_one_action, exec_fire,
        $onehot0({do_pop, do_fresh, do_push}))
endmodule
